/* sv/pdr_pkg.sv */
// Shared types, codes and fixed-point constants for the delta-R pair matcher.
package pdr_pkg;

	// Payload field types
	typedef logic signed [13:0] eta_t;
	typedef logic signed [12:0] phi_t;
	typedef logic [15:0]        pt_t;
	typedef logic [1:0]         req_code_t;

	// Request codes; the fourth code is ignored
	typedef enum logic [1:0] {
		REQ_LOAD_PART = 2'd0,
		REQ_LOAD_ANTI = 2'd1,
		REQ_EVAL      = 2'd2
	} req_t;

	// One stored list entry
	typedef struct packed {
		eta_t eta;
		phi_t phi;
		pt_t  pt;
	} entry_t;

	// Controls for the shared squaring unit
	typedef struct packed {
		logic load_eta;
		logic load_phi;
	} dist_ctl_t;

	// Sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_FETCH,
		ST_SQ_ETA,
		ST_SQ_PHI,
		ST_CMP,
		ST_ROW,
		ST_ROOT_GO,
		ST_ROOT,
		ST_DONE
	} state_t;

	// Widths of the datapath
	localparam int MAG_W  = 14;  // magnitude of an eta or wrapped phi difference
	localparam int SQ_W   = 28;  // one square
	localparam int D2_W   = 29;  // squared delta-R
	localparam int ROOT_W = 15;  // distance
	localparam int DPHI_W = 14;  // raw phi difference

	// Angles in units of 1/1024 rad
	localparam logic signed [DPHI_W-1:0] PI_FX     = 14'sd3217;
	localparam logic signed [DPHI_W-1:0] NEG_PI_FX = -14'sd3217;
	localparam logic signed [DPHI_W-1:0] TWO_PI_FX = 14'sd6434;

	// Highest even bit of a squared delta-R, start of the root recurrence
	localparam logic [D2_W-1:0] ROOT_TOP_BIT = {1'b1, 28'd0};

	// Configuration port
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;
	localparam logic REG_PT_PAIR_CUT = 1'b0;  // register index, byte address bit 2

endpackage

/* sv/pdr_if.sv */
// Valid/ready channel interfaces for request items and match results.
interface pdr_item_if import pdr_pkg::*; ();
	logic      valid;
	logic      ready;
	req_code_t req_type;
	eta_t      eta;
	phi_t      phi;
	pt_t       pt;

	modport source (output valid, req_type, eta, phi, pt, input ready);
	modport sink (input valid, req_type, eta, phi, pt, output ready);
endinterface

interface pdr_result_if import pdr_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              pair_found;
	logic [ROOT_W-1:0] distance;
	logic              overflowed;

	modport source (output valid, pair_found, distance, overflowed, input ready);
	modport sink (input valid, pair_found, distance, overflowed, output ready);
endinterface

/* sv/pair_delta_r_max_min_match.sv */
// Top level: max-min delta-R pair matcher with list storage and sequencer.
//
//   channel  dir  handshake            payload
//   item     in   item.valid/ready     req_type, eta, phi, pt
//   result   out  result.valid/ready   pair_found, distance, overflowed
//   apb      in   psel/penable/pwrite  paddr, pwdata -> prdata (pt_pair_cut)
//
// A load is taken while the block is idle. An evaluate with np particles and
// na antiparticles holds item.ready low until its result is posted: each
// pair costs a memory fetch, two passes through the single shared squarer and
// a compare, each row adds a row step, and the root unit runs when a pair is
// found. Without a counted pair the root is skipped. An evaluate on an empty
// list goes straight to the result. Reset clears the counts, flags and
// pt_pair_cut; list contents are not cleared.
// A result that is held by result.ready stalls only the end of the next evaluate.
module pair_delta_r_max_min_match import pdr_pkg::*; #(
	parameter int MAX_PARTONS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	pdr_item_if.sink              item,
	pdr_result_if.source          result,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready
);

	localparam int IW = (MAX_PARTONS > 1) ? $clog2(MAX_PARTONS) : 1;
	localparam int CW = $clog2(MAX_PARTONS + 1);
	localparam logic [CW-1:0] FULL = CW'(MAX_PARTONS);

	state_t            state_q, state_d;
	pt_t               cut_q;
	logic [CW-1:0]     part_cnt_q, anti_cnt_q;
	logic [CW-1:0]     i_q, j_q;
	logic              drop_q;
	logic              ovf_q;
	logic [D2_W-1:0]   dmin_q, best_q;
	logic              ok_q, found_q;
	logic              res_valid_q, res_found_q, res_ovf_q;
	logic [ROOT_W-1:0] res_dist_q;

	logic              item_ready, item_acc, eval_acc;
	logic              part_wr, anti_wr, load_full;
	logic              cfg_wr;
	logic              last_i, last_j, take;
	logic              sq_start, sq_busy, res_load;
	logic [ROOT_W-1:0] root;
	logic [D2_W-1:0]   d2;
	dist_ctl_t         dctl;
	entry_t            wr_entry, part_rd, anti_rd;

	// Configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_PT_PAIR_CUT);
	assign prdata = (paddr[2] == REG_PT_PAIR_CUT) ? {16'd0, cut_q} : '0;

	// Request decode
	assign item.ready = item_ready;
	assign item_acc   = item.valid && item_ready;
	assign eval_acc   = item_acc && (item.req_type == REQ_EVAL);
	assign part_wr    = item_acc && (item.req_type == REQ_LOAD_PART) && (part_cnt_q != FULL);
	assign anti_wr    = item_acc && (item.req_type == REQ_LOAD_ANTI) && (anti_cnt_q != FULL);
	assign load_full  = item_acc && (((item.req_type == REQ_LOAD_PART) && (part_cnt_q == FULL)) ||
	                                 ((item.req_type == REQ_LOAD_ANTI) && (anti_cnt_q == FULL)));
	assign wr_entry   = '{eta: item.eta, phi: item.phi, pt: item.pt};

	// Pair walk position
	assign last_i = (i_q + CW'(1)) == part_cnt_q;
	assign last_j = (j_q + CW'(1)) == anti_cnt_q;
	assign take   = (j_q == '0) || (d2 < dmin_q);

	pdr_list #(.DEPTH(MAX_PARTONS), .AW(IW)) u_part (
		.clk     (clk),
		.wr_en   (part_wr),
		.wr_addr (part_cnt_q[IW-1:0]),
		.wr_data (wr_entry),
		.rd_addr (i_q[IW-1:0]),
		.rd_data (part_rd)
	);

	pdr_list #(.DEPTH(MAX_PARTONS), .AW(IW)) u_anti (
		.clk     (clk),
		.wr_en   (anti_wr),
		.wr_addr (anti_cnt_q[IW-1:0]),
		.wr_data (wr_entry),
		.rd_addr (j_q[IW-1:0]),
		.rd_data (anti_rd)
	);

	pdr_dist u_dist (
		.clk  (clk),
		.ctl  (dctl),
		.part (part_rd),
		.anti (anti_rd),
		.d2_q (d2)
	);

	pdr_isqrt u_isqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sq_start),
		.value  (best_q),
		.busy   (sq_busy),
		.root   (root)
	);

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and sequencer outputs
	always_comb begin
		state_d    = state_q;
		item_ready = 1'b0;
		dctl       = '0;
		sq_start   = 1'b0;
		res_load   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				item_ready = 1'b1;
				if (item.valid && item.req_type == REQ_EVAL) begin
					state_d = (part_cnt_q == '0 || anti_cnt_q == '0) ? ST_DONE : ST_FETCH;
				end
			end
			ST_FETCH: begin
				state_d = ST_SQ_ETA;
			end
			ST_SQ_ETA: begin
				dctl.load_eta = 1'b1;
				state_d       = ST_SQ_PHI;
			end
			ST_SQ_PHI: begin
				dctl.load_phi = 1'b1;
				state_d       = ST_CMP;
			end
			ST_CMP: begin
				state_d = last_j ? ST_ROW : ST_FETCH;
			end
			ST_ROW: begin
				state_d = last_i ? ST_ROOT_GO : ST_FETCH;
			end
			ST_ROOT_GO: begin
				sq_start = found_q;
				state_d  = found_q ? ST_ROOT : ST_DONE;
			end
			ST_ROOT: begin
				if (!sq_busy) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!res_valid_q || result.ready) begin
					res_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Control registers: config, counts, flags, walk indexes, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cut_q       <= '0;
			part_cnt_q  <= '0;
			anti_cnt_q  <= '0;
			drop_q      <= 1'b0;
			i_q         <= '0;
			j_q         <= '0;
			found_q     <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (cfg_wr) begin
				cut_q <= pwdata[15:0];
			end
			if (part_wr) begin
				part_cnt_q <= part_cnt_q + CW'(1);
			end
			if (anti_wr) begin
				anti_cnt_q <= anti_cnt_q + CW'(1);
			end
			if (load_full) begin
				drop_q <= 1'b1;
			end
			// Start a walk; the drop flag moves into the pending result
			if (eval_acc) begin
				drop_q  <= 1'b0;
				i_q     <= '0;
				j_q     <= '0;
				found_q <= 1'b0;
			end
			if (state_q == ST_CMP) begin
				j_q <= last_j ? '0 : j_q + CW'(1);
			end
			if (state_q == ST_ROW) begin
				if (ok_q && (!found_q || dmin_q > best_q)) begin
					found_q <= 1'b1;
				end
				if (!last_i) begin
					i_q <= i_q + CW'(1);
				end
			end
			// Empty both lists when the result is posted
			if (res_load) begin
				part_cnt_q  <= '0;
				anti_cnt_q  <= '0;
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers: row minimum, best pair, result payload
	always_ff @(posedge clk) begin
		if (eval_acc) begin
			ovf_q  <= drop_q;
			best_q <= '0;
		end
		// Keep the first smallest distance of the row and its pt check
		if (state_q == ST_CMP && take) begin
			dmin_q <= d2;
			ok_q   <= (part_rd.pt >= cut_q) && (anti_rd.pt >= cut_q);
		end
		// Keep the largest counted row minimum
		if (state_q == ST_ROW && ok_q && (!found_q || dmin_q > best_q)) begin
			best_q <= dmin_q;
		end
		if (res_load) begin
			res_found_q <= found_q;
			res_dist_q  <= found_q ? root : '0;
			res_ovf_q   <= ovf_q;
		end
	end

	assign result.valid      = res_valid_q;
	assign result.pair_found = res_found_q;
	assign result.distance   = res_dist_q;
	assign result.overflowed = res_ovf_q;

endmodule

/* sv/pdr_list.sv */
// One entry list: single write port, single registered read port.
module pdr_list import pdr_pkg::*; #(
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  entry_t        wr_data,
	input  logic [AW-1:0] rd_addr,
	output entry_t        rd_data
);

	entry_t mem [DEPTH];

	// Write a loaded entry
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Register the read data
	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end

endmodule

/* sv/pdr_dist.sv */
// Shared squaring unit: builds one squared delta-R over two passes.
module pdr_dist import pdr_pkg::*; (
	input  logic            clk,
	input  dist_ctl_t       ctl,
	input  entry_t          part,
	input  entry_t          anti,
	output logic [D2_W-1:0] d2_q
);

	logic signed [MAG_W:0]    deta;
	logic [MAG_W-1:0]         deta_mag;
	logic signed [DPHI_W-1:0] dphi_raw;
	logic signed [DPHI_W-1:0] dphi_wrap;
	logic signed [DPHI_W-1:0] dphi_q;
	logic [MAG_W-1:0]         dphi_mag;
	logic [MAG_W-1:0]         sq_op;
	logic [SQ_W-1:0]          sq;
	logic [SQ_W-1:0]          acc_q;

	// Eta difference and its magnitude
	assign deta     = {part.eta[13], part.eta} - {anti.eta[13], anti.eta};
	assign deta_mag = deta[MAG_W] ? MAG_W'(-deta) : deta[MAG_W-1:0];

	// Wrap the phi difference into (-pi, pi]; one step covers every 13-bit input
	assign dphi_raw = {part.phi[12], part.phi} - {anti.phi[12], anti.phi};
	always_comb begin
		if (dphi_raw > PI_FX) begin
			dphi_wrap = dphi_raw - TWO_PI_FX;
		end else if (dphi_raw <= NEG_PI_FX) begin
			dphi_wrap = dphi_raw + TWO_PI_FX;
		end else begin
			dphi_wrap = dphi_raw;
		end
	end
	assign dphi_mag = dphi_q[DPHI_W-1] ? MAG_W'(-dphi_q) : dphi_q;

	// The one squarer, shared by both passes
	assign sq_op = ctl.load_eta ? deta_mag : dphi_mag;
	assign sq    = sq_op * sq_op;

	// First pass holds eta squared and the wrapped phi; second pass sums
	always_ff @(posedge clk) begin
		if (ctl.load_eta) begin
			acc_q  <= sq;
			dphi_q <= dphi_wrap;
		end
		if (ctl.load_phi) begin
			d2_q <= {1'b0, acc_q} + {1'b0, sq};
		end
	end

endmodule

/* sv/pdr_isqrt.sv */
// Integer square root, one result bit per cycle.
module pdr_isqrt import pdr_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [D2_W-1:0]   value,
	output logic              busy,
	output logic [ROOT_W-1:0] root
);

	logic              busy_q;
	logic [D2_W-1:0]   rem_q;
	logic [D2_W-1:0]   res_q;
	logic [D2_W-1:0]   bit_q;
	logic [D2_W-1:0]   trial;

	assign trial = res_q + bit_q;
	assign busy  = busy_q;
	assign root  = res_q[ROOT_W-1:0];

	// Track the running recurrence
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
		end else if (busy_q && bit_q == D2_W'(1)) begin
			busy_q <= 1'b0;
		end
	end

	// Subtract the trial value when it fits, shift the root otherwise
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= value;
			res_q <= '0;
			bit_q <= ROOT_TOP_BIT;
		end else if (busy_q) begin
			if (rem_q >= trial) begin
				rem_q <= rem_q - trial;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

endmodule

/* sv/pdr_chk.sv */
// Port-level checks for the pair matcher, bound to the top level.
module pdr_chk import pdr_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              item_valid,
	input logic              item_ready,
	input req_code_t         item_req_type,
	input logic              result_valid,
	input logic              result_ready,
	input logic              result_pair_found,
	input logic [ROOT_W-1:0] result_distance,
	input logic              result_overflowed
);

	logic eval_acc, load_acc;

	assign eval_acc = item_valid && item_ready && (item_req_type == REQ_EVAL);
	assign load_acc = item_valid && item_ready && (item_req_type != REQ_EVAL);

	// An evaluate occupies the block on the following cycle
	a_eval_busy: assert property (@(posedge clk) disable iff (!arst_n)
		eval_acc |=> !item_ready)
		else $error("item ready right after an evaluate");

	// A load never produces a result
	a_load_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		load_acc && !result_valid |=> !result_valid)
		else $error("result raised by a load");

	// No pair means zero distance
	a_none_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_pair_found |-> result_distance == '0)
		else $error("nonzero distance without a pair");

	// A stalled result holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result_pair_found) &&
			$stable(result_distance) && $stable(result_overflowed))
		else $error("stalled result changed");

endmodule

bind pair_delta_r_max_min_match pdr_chk u_pdr_chk (
	.clk               (clk),
	.arst_n            (arst_n),
	.item_valid        (item.valid),
	.item_ready        (item.ready),
	.item_req_type     (item.req_type),
	.result_valid      (result.valid),
	.result_ready      (result.ready),
	.result_pair_found (result.pair_found),
	.result_distance   (result.distance),
	.result_overflowed (result.overflowed)
);
